// ===== rtl/core/rtcm_pkg.sv =====
// shared types, constants and the byte-wide crc-24q update for the rtcm3 deframer
// no dependencies
package rtcm_pkg;

	localparam logic [7:0]  PREAMBLE        = 8'hD3;
	localparam logic [24:0] CRC24Q_POLY     = 25'h1864CFB;
	localparam logic [1:0]  LEN_HI_MASK     = 2'h3;
	localparam logic [10:0] MAX_FRAME_RESET = 11'd1029;
	localparam logic [15:0] ERR_COUNT_MAX   = 16'hFFFF;

	// register index of max_frame_bytes
	localparam logic REG_MAX_FRAME = 1'b0;

	typedef enum logic [6:0] {
		PH_HUNT    = 7'b0000001,
		PH_LEN_HI  = 7'b0000010,
		PH_LEN_LO  = 7'b0000100,
		PH_PAYLOAD = 7'b0001000,
		PH_CRC1    = 7'b0010000,
		PH_CRC2    = 7'b0100000,
		PH_CRC3    = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_BAD_LEN = 2'd1,
		ERR_TOO_BIG = 2'd2
	} frame_err_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic        in_frame;
		logic        frame_first;
		logic        frame_last;
		logic        crc_ok;
		frame_err_t  frame_error;
		logic [15:0] error_total;
	} result_t;

	// msb first, no reflection, no final xor
	function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
		logic [24:0] c;
		c = {1'b0, crc ^ {b, 16'h0000}};
		for (int k = 0; k < 8; k++) begin
			c = {c[23:0], 1'b0};
			if (c[24]) begin
				c = c ^ CRC24Q_POLY;
			end
		end
		return c[23:0];
	endfunction

endpackage

// ===== rtl/core/rtcm_framer.sv =====
// framing state machine, byte counter, crc accumulator and error counter
// depends on rtcm_pkg
module rtcm_framer import rtcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic [10:0] max_frame_bytes,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic [1:0]  prev_low_bits_q, prev_low_bits_d;
	logic [9:0]  payload_length_q, payload_length_d;
	logic [10:0] byte_count_q, byte_count_d;
	logic [23:0] crc_accum_q, crc_accum_d;
	logic [23:0] received_crc_q, received_crc_d;
	logic [15:0] error_counter_q, error_counter_d;

	logic [23:0] crc_upd;
	logic [10:0] count_inc;
	logic [23:0] rx_crc_shift;
	logic [9:0]  len_w;
	logic        count_err;

	assign crc_upd      = crc24q_byte(crc_accum_q, data_byte);
	assign count_inc    = byte_count_q + 11'd1;
	assign rx_crc_shift = {received_crc_q[15:0], data_byte};
	assign len_w        = {prev_low_bits_q, data_byte};

	always_comb begin
		phase_d          = phase_q;
		prev_low_bits_d  = prev_low_bits_q;
		payload_length_d = payload_length_q;
		byte_count_d     = byte_count_q;
		crc_accum_d      = crc_accum_q;
		received_crc_d   = received_crc_q;
		count_err        = 1'b0;
		res.byte_out     = data_byte;
		res.in_frame     = 1'b0;
		res.frame_first  = 1'b0;
		res.frame_last   = 1'b0;
		res.crc_ok       = 1'b0;
		res.frame_error  = ERR_NONE;
		case (phase_q)
			PH_LEN_HI: begin
				res.in_frame    = 1'b1;
				prev_low_bits_d = data_byte[1:0] & LEN_HI_MASK;
				crc_accum_d     = crc_upd;
				byte_count_d    = count_inc;
				phase_d         = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				res.in_frame     = 1'b1;
				payload_length_d = len_w;
				crc_accum_d      = crc_upd;
				byte_count_d     = count_inc;
				if (len_w == 10'd0 || {1'b0, len_w} > max_frame_bytes) begin
					res.frame_last  = 1'b1;
					res.frame_error = ERR_BAD_LEN;
					count_err       = 1'b1;
					phase_d         = PH_HUNT;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				res.in_frame = 1'b1;
				crc_accum_d  = crc_upd;
				byte_count_d = count_inc;
				// header plus payload done
				if ({1'b0, count_inc} >= {2'b00, payload_length_q} + 12'd3) begin
					phase_d = PH_CRC1;
				end
			end
			PH_CRC1: begin
				res.in_frame   = 1'b1;
				received_crc_d = rx_crc_shift;
				byte_count_d   = count_inc;
				phase_d        = PH_CRC2;
			end
			PH_CRC2: begin
				res.in_frame   = 1'b1;
				received_crc_d = rx_crc_shift;
				byte_count_d   = count_inc;
				phase_d        = PH_CRC3;
			end
			PH_CRC3: begin
				res.in_frame   = 1'b1;
				res.frame_last = 1'b1;
				received_crc_d = rx_crc_shift;
				byte_count_d   = count_inc;
				if (count_inc > max_frame_bytes) begin
					res.frame_error = ERR_TOO_BIG;
					count_err       = 1'b1;
				end else begin
					res.crc_ok = (rx_crc_shift == crc_accum_q);
				end
				phase_d = PH_HUNT;
			end
			default: begin
				// hunting, and any stray code
				phase_d = PH_HUNT;
				if (data_byte == PREAMBLE) begin
					res.in_frame     = 1'b1;
					res.frame_first  = 1'b1;
					payload_length_d = 10'd0;
					received_crc_d   = 24'd0;
					byte_count_d     = 11'd1;
					crc_accum_d      = crc24q_byte(24'd0, data_byte);
					phase_d          = PH_LEN_HI;
				end
			end
		endcase
		error_counter_d = error_counter_q;
		if (count_err && error_counter_q != ERR_COUNT_MAX) begin
			error_counter_d = error_counter_q + 16'd1;
		end
		res.error_total = error_counter_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_HUNT;
			prev_low_bits_q  <= 2'd0;
			payload_length_q <= 10'd0;
			byte_count_q     <= 11'd0;
			crc_accum_q      <= 24'd0;
			received_crc_q   <= 24'd0;
			error_counter_q  <= 16'd0;
		end else if (step) begin
			phase_q          <= phase_d;
			prev_low_bits_q  <= prev_low_bits_d;
			payload_length_q <= payload_length_d;
			byte_count_q     <= byte_count_d;
			crc_accum_q      <= crc_accum_d;
			received_crc_q   <= received_crc_d;
			error_counter_q  <= error_counter_d;
		end
	end

	a_last_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.frame_last |=> phase_q == PH_HUNT)
		else $error("frame end did not return to hunting");

	a_first_to_len: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.frame_first |=> phase_q == PH_LEN_HI)
		else $error("preamble did not open the header");

	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.frame_error != ERR_NONE && error_counter_q != ERR_COUNT_MAX
		|=> error_counter_q == $past(error_counter_q) + 16'd1)
		else $error("error count did not advance on a framing error");

	a_ok_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.crc_ok |-> res.frame_last && res.frame_error == ERR_NONE)
		else $error("crc_ok outside a clean frame end");

endmodule

// ===== rtl/core/rtcm3_frame_deframer_crc24q.sv =====
// rtcm3 deframer top level: apb register, input handshake and output register
// depends on rtcm_pkg and rtcm_framer
// a byte transferred in shows up on the output register in the next cycle
// throughput: one byte per cycle while the output drains, set by the byte-wide crc-24q update and framing fsm
// in_ready is high while the output register is empty or being drained
// reset: arst_n clears the framing state, error count and output valid at once;
// max_frame_bytes returns to 1029
module rtcm3_frame_deframer_crc24q import rtcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  byte_out,
	output logic        in_frame,
	output logic        frame_first,
	output logic        frame_last,
	output logic        crc_ok,
	output logic [1:0]  frame_error,
	output logic [15:0] error_total
);

	logic [10:0] max_frame_bytes_q;
	logic        out_valid_q;
	result_t     res;
	result_t     res_q;
	logic        step;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_bytes_q <= MAX_FRAME_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_MAX_FRAME) begin
			max_frame_bytes_q <= pwdata[10:0];
		end
	end

	assign prdata = (paddr[2] == REG_MAX_FRAME) ? {21'd0, max_frame_bytes_q} : 32'd0;

	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	rtcm_framer u_framer (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.data_byte       (data_byte),
		.max_frame_bytes (max_frame_bytes_q),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign byte_out    = res_q.byte_out;
	assign in_frame    = res_q.in_frame;
	assign frame_first = res_q.frame_first;
	assign frame_last  = res_q.frame_last;
	assign crc_ok      = res_q.crc_ok;
	assign frame_error = res_q.frame_error;
	assign error_total = res_q.error_total;

endmodule

// ===== test/tb.sv =====
// testbench for rtcm3_frame_deframer_crc24q: byte stream in, marked echo out
// checked against a local predictor; depends on rtcm_pkg and the deframer rtl
module tb;
	import rtcm_pkg::*;

	localparam int IDLE_PCT       = 36;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int FINAL_WAIT     = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  byte_out;
	logic        in_frame;
	logic        frame_first;
	logic        frame_last;
	logic        crc_ok;
	logic [1:0]  frame_error;
	logic [15:0] error_total;

	// predictor state
	phase_t      ph = PH_HUNT;
	logic [1:0]  hdr_low_bits = '0;
	logic [9:0]  pay_len = '0;
	logic [10:0] frame_byte_cnt = '0;
	logic [23:0] crc_running = '0;
	logic [23:0] crc_received = '0;
	logic [15:0] framing_err_cnt = '0;
	logic [10:0] frame_limit = MAX_FRAME_RESET;

	result_t     expected_echo_q[$];
	result_t     expected_result;
	int          mismatches = 0;
	int          stall_cycles = 0;
	int          bytes_sent = 0;
	bit          no_idle = 1'b0;

	rtcm3_frame_deframer_crc24q i_dut (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

	// bit-serial crc-24q, msb first
	function automatic logic [23:0] crc24_step(input logic [23:0] crc, input logic [7:0] b);
		logic [23:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[23] ^ b[i];
			c = {c[22:0], 1'b0};
			if (fb) begin
				c = c ^ CRC24Q_POLY[23:0];
			end
		end
		return c;
	endfunction

	function automatic void bump_err_cnt();
		if (framing_err_cnt != ERR_COUNT_MAX) begin
			framing_err_cnt = framing_err_cnt + 16'd1;
		end
	endfunction

	function automatic result_t deframe_byte(input logic [7:0] b);
		result_t r;
		r = '0;
		r.frame_error = ERR_NONE;
		r.byte_out = b;
		case (ph)
			PH_LEN_HI: begin
				r.in_frame = 1'b1;
				hdr_low_bits = b[1:0] & LEN_HI_MASK;
				crc_running = crc24_step(crc_running, b);
				frame_byte_cnt = frame_byte_cnt + 11'd1;
				ph = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				r.in_frame = 1'b1;
				pay_len = {hdr_low_bits, b};
				crc_running = crc24_step(crc_running, b);
				frame_byte_cnt = frame_byte_cnt + 11'd1;
				if (pay_len == 10'd0 || {1'b0, pay_len} > frame_limit) begin
					r.frame_last = 1'b1;
					r.frame_error = ERR_BAD_LEN;
					bump_err_cnt();
					ph = PH_HUNT;
				end else begin
					ph = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				r.in_frame = 1'b1;
				crc_running = crc24_step(crc_running, b);
				frame_byte_cnt = frame_byte_cnt + 11'd1;
				if (frame_byte_cnt >= {1'b0, pay_len} + 11'd3) begin
					ph = PH_CRC1;
				end
			end
			PH_CRC1, PH_CRC2: begin
				r.in_frame = 1'b1;
				crc_received = {crc_received[15:0], b};
				frame_byte_cnt = frame_byte_cnt + 11'd1;
				ph = (ph == PH_CRC1) ? PH_CRC2 : PH_CRC3;
			end
			PH_CRC3: begin
				r.in_frame = 1'b1;
				r.frame_last = 1'b1;
				crc_received = {crc_received[15:0], b};
				frame_byte_cnt = frame_byte_cnt + 11'd1;
				if (frame_byte_cnt > frame_limit) begin
					r.frame_error = ERR_TOO_BIG;
					bump_err_cnt();
				end else begin
					r.crc_ok = (crc_received == crc_running);
				end
				ph = PH_HUNT;
			end
			default: begin
				ph = PH_HUNT;
				if (b == PREAMBLE) begin
					r.in_frame = 1'b1;
					r.frame_first = 1'b1;
					pay_len = '0;
					crc_received = '0;
					frame_byte_cnt = 11'd1;
					crc_running = crc24_step(24'd0, b);
					ph = PH_LEN_HI;
				end
			end
		endcase
		r.error_total = framing_err_cnt;
		return r;
	endfunction

	function automatic void report_field(input string fname, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h, got %h", $time, fname, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_echo_q.size() == 0) begin
					mismatches++;
					$display("%0t: byte_out expected nothing pending, got %h", $time, byte_out);
				end else begin
					expected_result = expected_echo_q.pop_front();
					report_field("byte_out", 16'(expected_result.byte_out), 16'(byte_out));
					report_field("in_frame", 16'(expected_result.in_frame), 16'(in_frame));
					report_field("frame_first", 16'(expected_result.frame_first), 16'(frame_first));
					report_field("frame_last", 16'(expected_result.frame_last), 16'(frame_last));
					report_field("crc_ok", 16'(expected_result.crc_ok), 16'(crc_ok));
					report_field("frame_error", 16'(expected_result.frame_error), 16'(frame_error));
					report_field("error_total", expected_result.error_total, error_total);
				end
			end
			if (in_valid && in_ready) begin
				expected_echo_q.insert(expected_echo_q.size(), deframe_byte(data_byte));
			end
			if ((out_valid && out_ready) || (in_valid && in_ready) || psel) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("** rtcm3_frame_deframer_crc24q: FAILED **");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (!no_idle && $urandom_range(99) < IDLE_PCT);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	// header only when the length is rejected, else payload and crc (optionally corrupted)
	task automatic send_frame(input int len, input bit good_crc);
		logic [7:0]  pkt[$];
		logic [9:0]  l;
		logic [23:0] crc;
		l = len[9:0];
		pkt.insert(pkt.size(), PREAMBLE);
		pkt.insert(pkt.size(), {6'($urandom), l[9:8]});
		pkt.insert(pkt.size(), l[7:0]);
		if (l != 10'd0 && {1'b0, l} <= frame_limit) begin
			repeat (int'(l)) pkt.insert(pkt.size(), 8'($urandom));
			crc = '0;
			foreach (pkt[i]) crc = crc24_step(crc, pkt[i]);
			if (!good_crc) begin
				crc = crc ^ (24'd1 << $urandom_range(23));
			end
			pkt.insert(pkt.size(), crc[23:16]);
			pkt.insert(pkt.size(), crc[15:8]);
			pkt.insert(pkt.size(), crc[7:0]);
		end
		foreach (pkt[i]) send_byte(pkt[i]);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_echo_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_frame_limit(input logic [10:0] value);
		logic [31:0] wdata;
		wait_for_results();
		wdata = $urandom;
		wdata[10:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_MAX_FRAME, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		frame_limit = value;
		// read back
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		report_field("max_frame_bytes", 16'(value), 16'(prdata[10:0]));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_directed_frames();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(1, 1'b1);
		send_frame(2, 1'b0);
		// upper bits of the first length byte ignored, zero length rejected
		send_byte(PREAMBLE);
		send_byte(8'hFC);
		send_byte(8'h00);
	endtask

	task automatic test_frame_limits();
		int limit_values[$];
		int lens[$];
		int len;
		limit_values = '{6, 0, 3, 20, 40, 2047, 1029};
		foreach (limit_values[k]) begin
			write_frame_limit(11'(limit_values[k]));
			if (limit_values[k] == 40) begin
				// rejected length whose low byte is a preamble: not picked up as a new frame
				send_byte(PREAMBLE);
				send_byte(8'h00);
				send_byte(PREAMBLE);
				send_byte(8'h00);
			end
			lens = '{1, limit_values[k] - 6, limit_values[k] - 5, limit_values[k],
				limit_values[k] + 1};
			foreach (lens[j]) begin
				len = lens[j];
				if (len < 0) len = 0;
				if (len > 1023) len = 1023;
				// accepted frames over 64 bytes are not sent
				if (len > 58 && len <= limit_values[k]) continue;
				send_frame(len, $urandom_range(3) != 0);
			end
		end
	endtask

	task automatic test_random_traffic();
		int   limit_values[$];
		int   start;
		int   r;
		bit   paused;
		logic [7:0] b;
		limit_values = '{6, 30, 200, 1029, int'($urandom_range(2047))};
		paused = 1'b0;
		foreach (limit_values[k]) begin
			write_frame_limit(11'(limit_values[k]));
			start = bytes_sent;
			while (bytes_sent - start < 20) begin
				r = $urandom_range(99);
				if (r < 70) begin
					send_frame($urandom_range(30), $urandom_range(4) != 0);
				end else if (r < 80) begin
					// broken frame: preamble and a few bytes, then whatever follows
					send_byte(PREAMBLE);
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
				end else if (r < 92) begin
					do b = 8'($urandom); while (b == PREAMBLE);
					send_byte(b);
				end else begin
					send_byte(8'($urandom));
				end
				if (k == 2 && !paused && bytes_sent - start >= 10) begin
					paused = 1'b1;
					wait_for_results();
				end
			end
		end
	endtask

	// back-to-back rejected headers and frames with no idling on either side
	task automatic test_error_burst();
		wait_for_results();
		no_idle = 1'b1;
		repeat (8) begin
			send_byte(PREAMBLE);
			send_byte(8'h00);
			send_byte(8'h00);
		end
		send_frame(4, 1'b1);
		send_frame(0, 1'b1);
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_frames();
		test_frame_limits();
		test_random_traffic();
		test_error_burst();
		wait_for_results();
		repeat (FINAL_WAIT) @(posedge clk);
		if (mismatches == 0 && expected_echo_q.size() == 0) begin
			$display("** rtcm3_frame_deframer_crc24q: PASSED **");
		end else begin
			$display("** rtcm3_frame_deframer_crc24q: FAILED **");
		end
		$finish;
	end

endmodule

// ===== rtcm3_frame_deframer_crc24q.f =====
rtl/core/rtcm_pkg.sv
rtl/core/rtcm_framer.sv
rtl/core/rtcm3_frame_deframer_crc24q.sv
test/tb.sv
